// ----- design/assert_macros.svh -----
// Assertion macros for the queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold on every rising clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- design/bsq_pkg.sv -----
// Types, constants and codes shared by the sorted priority queue.
package bsq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int TAG_W        = 16;
    localparam int PRIO_W       = 8;
    localparam int OCC_W        = 5;
    localparam int S_TDATA_W    = 24;
    localparam int M_TDATA_W    = 32;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_HOLD = 1'b1
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic    load;       // beat accepted: update result register
        logic    do_insert;  // insert into sorted array
        logic    do_remove;  // pop head entry
        t_status status;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic empty;
        logic full;
    } t_dp_stat;

endpackage

// ----- design/bsq_ctrl.sv -----
// Controller: handshake state machine and command decode for the queue.
module bsq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic              i_cmd,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    input  bsq_pkg::t_dp_stat i_stat,
    output bsq_pkg::t_dp_cmd  o_cmd
);

    bsq_pkg::t_state r_state;
    bsq_pkg::t_state n_state;
    logic            accept;
    bsq_pkg::t_cmd   cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bsq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        cmd        = bsq_pkg::t_cmd'(i_cmd);
        // a held result leaving this cycle frees the output register
        o_s_tready = (r_state == bsq_pkg::S_IDLE) || i_m_tready;
        o_m_tvalid = (r_state == bsq_pkg::S_HOLD);
        accept     = i_s_tvalid && o_s_tready;
        n_state    = r_state;
        case (r_state)
            bsq_pkg::S_IDLE: begin
                if (accept) n_state = bsq_pkg::S_HOLD;
            end
            bsq_pkg::S_HOLD: begin
                if (!accept && i_m_tready) n_state = bsq_pkg::S_IDLE;
            end
            default: n_state = bsq_pkg::S_IDLE;
        endcase

        o_cmd.load      = accept;
        o_cmd.do_insert = 1'b0;
        o_cmd.do_remove = 1'b0;
        o_cmd.status    = bsq_pkg::STAT_OK;
        case (cmd)
            bsq_pkg::CMD_INSERT: begin
                if (i_stat.full) o_cmd.status = bsq_pkg::STAT_FULL;
                else             o_cmd.do_insert = accept;
            end
            bsq_pkg::CMD_REMOVE: begin
                if (i_stat.empty) o_cmd.status = bsq_pkg::STAT_EMPTY;
                else              o_cmd.do_remove = accept;
            end
            default: o_cmd.status = bsq_pkg::STAT_OK;
        endcase
    end

endmodule

// ----- design/bsq_dpath.sv -----
// Datapath: sorted entry cells with parallel compare-and-shift, count and result register.
`include "assert_macros.svh"

module bsq_dpath #(
    parameter int CAPACITY = bsq_pkg::CAPACITY_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bsq_pkg::t_dp_cmd           i_cmd,
    input  logic [bsq_pkg::TAG_W-1:0]  i_tag,
    input  logic [bsq_pkg::PRIO_W-1:0] i_prio,
    output bsq_pkg::t_dp_stat          o_stat,
    output bsq_pkg::t_status           o_status,
    output logic [bsq_pkg::TAG_W-1:0]  o_tag,
    output logic [bsq_pkg::PRIO_W-1:0] o_prio,
    output logic [bsq_pkg::OCC_W-1:0]  o_occ,
    output logic                       o_empty,
    output logic                       o_full
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [bsq_pkg::TAG_W-1:0]  r_tag  [CAPACITY];
    logic [bsq_pkg::PRIO_W-1:0] r_prio [CAPACITY];
    logic [CW-1:0]              r_count;
    logic [CW-1:0]              n_count;
    logic [CAPACITY-1:0]        ge;   // occupied slot that stays ahead of the new entry

    bsq_pkg::t_status           r_status;
    logic [bsq_pkg::TAG_W-1:0]  r_otag;
    logic [bsq_pkg::PRIO_W-1:0] r_oprio;
    logic [bsq_pkg::OCC_W-1:0]  r_occ;
    logic                       r_empty;
    logic                       r_full;

    always_comb begin
        o_stat.empty = (r_count == '0);
        o_stat.full  = (r_count == CW'(CAPACITY));
        n_count      = r_count;
        if (i_cmd.do_insert)      n_count = r_count + 1'b1;
        else if (i_cmd.do_remove) n_count = r_count - 1'b1;
    end

    for (genvar k = 0; k < CAPACITY; k++) begin : g_slot
        assign ge[k] = (CW'(k) < r_count) && (r_prio[k] >= i_prio);

        always_ff @(posedge i_clk) begin
            if (i_cmd.do_insert && !ge[k]) begin
                if (k == 0) begin
                    r_tag[k]  <= i_tag;
                    r_prio[k] <= i_prio;
                end else if (ge[(k == 0) ? 0 : k-1]) begin
                    r_tag[k]  <= i_tag;
                    r_prio[k] <= i_prio;
                end else begin
                    r_tag[k]  <= r_tag[(k == 0) ? 0 : k-1];
                    r_prio[k] <= r_prio[(k == 0) ? 0 : k-1];
                end
            end else if (i_cmd.do_remove && (k < CAPACITY - 1)) begin
                r_tag[k]  <= r_tag[(k < CAPACITY - 1) ? k+1 : k];
                r_prio[k] <= r_prio[(k < CAPACITY - 1) ? k+1 : k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_status <= i_cmd.status;
            r_otag   <= i_cmd.do_remove ? r_tag[0]  : '0;
            r_oprio  <= i_cmd.do_remove ? r_prio[0] : '0;
            r_occ    <= bsq_pkg::OCC_W'(n_count);
            r_empty  <= (n_count == '0);
            r_full   <= (n_count == CW'(CAPACITY));
        end
    end

    assign o_status = r_status;
    assign o_tag    = r_otag;
    assign o_prio   = r_oprio;
    assign o_occ    = r_occ;
    assign o_empty  = r_empty;
    assign o_full   = r_full;

    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CW'(CAPACITY))
    `ASSERT_ALWAYS(a_one_op, i_clk, i_rst_n, !(i_cmd.do_insert && i_cmd.do_remove))
    `ASSERT_NEXT(a_insert_count, i_clk, i_rst_n, i_cmd.do_insert, r_count == $past(r_count) + 1'b1)

endmodule

// ----- design/bounded_sorted_priority_queue_core.sv -----
// Top level of the bounded sorted priority queue: controller plus datapath.
//
// Usage:
//   Slave channel: one beat is one command. i_s_tuser carries the command
//   (0 insert, 1 remove head); i_s_tdata carries the tag and priority of an
//   insert, ignored on a remove.
//   Master channel: exactly one result beat per command, in order. o_m_tuser
//   carries the status (0 ok, 1 insert rejected full, 2 remove failed empty);
//   o_m_tdata carries removed tag/priority (zero otherwise), occupancy after
//   the operation, and the empty and full flags.
//   Latency: the result is valid the cycle after the command beat.
//   Throughput: one command per cycle while the receiver takes results; the
//   whole insert (compare of every slot and shift) or removal is done in the
//   single accept cycle by the per-slot cells.
//   Entries of equal priority leave in arrival order.
//   Reset: synchronous, active low; the queue becomes empty and no result is
//   pending. Slot contents are not cleared, only the count.
//   Stall: a result held for the receiver keeps its value; a new command is
//   taken only in a cycle in which the held result leaves.
module bounded_sorted_priority_queue_core #(
    parameter int CAPACITY = bsq_pkg::CAPACITY_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [bsq_pkg::S_TDATA_W-1:0]    i_s_tdata,  // [15:0] item_tag, [23:16] item_priority
    input  logic                             i_s_tuser,  // [0] cmd
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [bsq_pkg::M_TDATA_W-1:0]    o_m_tdata,  // [15:0] out_tag, [23:16] out_priority,
                                                         // [28:24] occupancy, [29] is_empty_flag,
                                                         // [30] is_full_flag, [31] zero
    output logic [1:0]                       o_m_tuser   // [1:0] status
);

    bsq_pkg::t_dp_cmd           dp_cmd;
    bsq_pkg::t_dp_stat          dp_stat;
    bsq_pkg::t_status           res_status;
    logic [bsq_pkg::TAG_W-1:0]  res_tag;
    logic [bsq_pkg::PRIO_W-1:0] res_prio;
    logic [bsq_pkg::OCC_W-1:0]  res_occ;
    logic                       res_empty;
    logic                       res_full;

    // Handshake and command decode
    bsq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_cmd      (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    // Sorted slot array and result register
    bsq_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (dp_cmd),
        .i_tag    (i_s_tdata[15:0]),
        .i_prio   (i_s_tdata[23:16]),
        .o_stat   (dp_stat),
        .o_status (res_status),
        .o_tag    (res_tag),
        .o_prio   (res_prio),
        .o_occ    (res_occ),
        .o_empty  (res_empty),
        .o_full   (res_full)
    );

    assign o_m_tdata = {1'b0, res_full, res_empty, res_occ, res_prio, res_tag};
    assign o_m_tuser = res_status;

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the bounded sorted priority queue core.
module tb;

    localparam int CAP         = bsq_pkg::CAPACITY_DEF;
    localparam int IDLE_PCT    = 35;
    localparam int RANDOM_OPS  = 2000;
    localparam int CYCLE_LIMIT = 200000;

    // One result beat, split into its fields.
    typedef struct packed {
        bsq_pkg::t_status           status;
        logic [bsq_pkg::TAG_W-1:0]  tag;
        logic [bsq_pkg::PRIO_W-1:0] prio;
        logic [bsq_pkg::OCC_W-1:0]  occ;
        logic                       empty;
        logic                       full;
    } t_queue_result;

    // One row of the directed table; want is used only where fixed is set.
    typedef struct {
        bsq_pkg::t_cmd              cmd;
        logic [bsq_pkg::TAG_W-1:0]  tag;
        logic [bsq_pkg::PRIO_W-1:0] prio;
        bit                         fixed;
        t_queue_result              want;
    } t_plan_row;

    logic                          i_clk      = 1'b0;
    logic                          i_rst_n    = 1'b0;
    logic                          i_s_tvalid = 1'b0;
    logic                          o_s_tready;
    logic [bsq_pkg::S_TDATA_W-1:0] i_s_tdata  = '0;
    logic                          i_s_tuser  = 1'b0;
    logic                          o_m_tvalid;
    logic                          i_m_tready = 1'b0;
    logic [bsq_pkg::M_TDATA_W-1:0] o_m_tdata;
    logic [1:0]                    o_m_tuser;

    // Mirror of the queue contents, packed from slot 0, highest priority first.
    logic [bsq_pkg::TAG_W-1:0]  held_tag  [CAP];
    logic [bsq_pkg::PRIO_W-1:0] held_prio [CAP];
    int                         held_count;

    t_queue_result due_results[$];  // results owed by the core, oldest first
    t_plan_row     plan[$];
    int            errors = 0;
    int            cycles = 0;
    bit            calm   = 1'b0;   // when set neither side idles

    bounded_sorted_priority_queue_core #(
        .CAPACITY (CAP)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Runaway guard.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("** bounded_sorted_priority_queue_core: FAILED **");
            $finish;
        end
    end

    // Applies one command to the mirror and returns the result it must give.
    // An insert goes behind every entry of greater or equal priority, so
    // equal priorities leave in arrival order.
    function automatic t_queue_result apply_queue_op(bsq_pkg::t_cmd c,
                                                     logic [bsq_pkg::TAG_W-1:0] tag,
                                                     logic [bsq_pkg::PRIO_W-1:0] pr);
        t_queue_result r;
        int pos;
        int k;
        r = '0;
        r.status = bsq_pkg::STAT_OK;
        if (c == bsq_pkg::CMD_INSERT) begin
            if (held_count >= CAP) begin
                r.status = bsq_pkg::STAT_FULL;
            end else begin
                pos = 0;
                while (pos < held_count && held_prio[pos] >= pr) pos++;
                for (k = held_count; k > pos; k--) begin
                    held_tag[k]  = held_tag[k-1];
                    held_prio[k] = held_prio[k-1];
                end
                held_tag[pos]  = tag;
                held_prio[pos] = pr;
                held_count++;
            end
        end else begin
            if (held_count == 0) begin
                r.status = bsq_pkg::STAT_EMPTY;
            end else begin
                r.tag  = held_tag[0];
                r.prio = held_prio[0];
                for (k = 1; k < held_count; k++) begin
                    held_tag[k-1]  = held_tag[k];
                    held_prio[k-1] = held_prio[k];
                end
                held_count--;
            end
        end
        r.occ   = held_count[bsq_pkg::OCC_W-1:0];
        r.empty = (held_count == 0);
        r.full  = (held_count == CAP);
        return r;
    endfunction

    // Result written out by hand for a directed row; flags follow from occ.
    function automatic t_queue_result fixed_result(bsq_pkg::t_status st,
                                                   logic [bsq_pkg::TAG_W-1:0] tag,
                                                   logic [bsq_pkg::PRIO_W-1:0] pr, int occ);
        t_queue_result r;
        r.status = st;
        r.tag    = tag;
        r.prio   = pr;
        r.occ    = occ[bsq_pkg::OCC_W-1:0];
        r.empty  = (occ == 0);
        r.full   = (occ == CAP);
        return r;
    endfunction

    task automatic add_row(bsq_pkg::t_cmd c, logic [bsq_pkg::TAG_W-1:0] tag,
                           logic [bsq_pkg::PRIO_W-1:0] pr, bit fixed, t_queue_result want);
        t_plan_row row;
        row.cmd   = c;
        row.tag   = tag;
        row.prio  = pr;
        row.fixed = fixed;
        row.want  = want;
        plan.push_back(row);
    endtask

    task automatic compare_field(string what, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
            errors++;
        end
    endtask

    // Presents one command beat and returns at the edge that takes it.
    // tvalid is left high; the next call or an idle cycle decides its level.
    task automatic send_beat(bsq_pkg::t_cmd c, logic [bsq_pkg::TAG_W-1:0] tag,
                             logic [bsq_pkg::PRIO_W-1:0] pr);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {pr, tag};
        i_s_tuser  <= c;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // Holds the sender off until every owed result has come back.
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (due_results.size() != 0) @(posedge i_clk);
    endtask

    // Result side: check each beat taken, then pick tready for the next edge.
    t_queue_result got_result;
    t_queue_result want_result;

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got_result.status = bsq_pkg::t_status'(o_m_tuser);
            got_result.tag    = o_m_tdata[15:0];
            got_result.prio   = o_m_tdata[23:16];
            got_result.occ    = o_m_tdata[28:24];
            got_result.empty  = o_m_tdata[29];
            got_result.full   = o_m_tdata[30];
            if (due_results.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, got %0h/%0h",
                         $time, o_m_tuser, o_m_tdata);
                errors++;
            end else begin
                want_result = due_results.pop_front();
                compare_field("status", 32'(want_result.status), 32'(got_result.status));
                compare_field("out_tag", 32'(want_result.tag), 32'(got_result.tag));
                compare_field("out_priority", 32'(want_result.prio), 32'(got_result.prio));
                compare_field("occupancy", 32'(want_result.occ), 32'(got_result.occ));
                compare_field("is_empty_flag", 32'(want_result.empty),
                              32'(got_result.empty));
                compare_field("is_full_flag", 32'(want_result.full), 32'(got_result.full));
                compare_field("tdata pad", 32'd0, 32'(o_m_tdata[31]));
            end
        end
        i_m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    initial begin
        t_queue_result              predicted;
        bsq_pkg::t_cmd              c;
        logic [bsq_pkg::TAG_W-1:0]  tag;
        logic [bsq_pkg::PRIO_W-1:0] pr;
        int                         ins_pct;
        int                         prio_mode;

        held_count = 0;

        // Directed table. Removes carry junk in tdata, which must be ignored.
        add_row(bsq_pkg::CMD_REMOVE, 16'hABCD, 8'h5A, 1'b1,
                fixed_result(bsq_pkg::STAT_EMPTY, '0, '0, 0));
        add_row(bsq_pkg::CMD_INSERT, 16'hFFFF, 8'hFF, 1'b1,
                fixed_result(bsq_pkg::STAT_OK, '0, '0, 1));
        add_row(bsq_pkg::CMD_REMOVE, 16'h0000, 8'h00, 1'b1,
                fixed_result(bsq_pkg::STAT_OK, 16'hFFFF, 8'hFF, 0));
        add_row(bsq_pkg::CMD_INSERT, 16'h0000, 8'h00, 1'b1,
                fixed_result(bsq_pkg::STAT_OK, '0, '0, 1));
        // equal priorities, must leave in arrival order
        add_row(bsq_pkg::CMD_INSERT, 16'h1111, 8'h00, 1'b0, '0);
        add_row(bsq_pkg::CMD_INSERT, 16'h2222, 8'h80, 1'b0, '0);
        add_row(bsq_pkg::CMD_INSERT, 16'h3333, 8'h80, 1'b0, '0);
        add_row(bsq_pkg::CMD_INSERT, 16'h4444, 8'hFF, 1'b0, '0);
        // fill to capacity with a spread of priorities
        for (int k = 0; k < CAP - 5; k++) begin
            add_row(bsq_pkg::CMD_INSERT, 16'h5000 + 16'(k), 8'(k * 23 + 1), 1'b0, '0);
        end
        // insert when full is rejected and leaves the queue as it was
        add_row(bsq_pkg::CMD_INSERT, 16'hBEEF, 8'hFE, 1'b1,
                fixed_result(bsq_pkg::STAT_FULL, '0, '0, CAP));
        for (int k = 0; k < 5; k++) begin
            add_row(bsq_pkg::CMD_REMOVE, 16'hFFFF, 8'hFF, 1'b0, '0);
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            send_beat(plan[i].cmd, plan[i].tag, plan[i].prio);
            predicted = apply_queue_op(plan[i].cmd, plan[i].tag, plan[i].prio);
            due_results.push_back(plan[i].fixed ? plan[i].want : predicted);
        end

        drain_results();

        // Random part: bursts that lean towards filling, draining or neither,
        // so full and empty are both visited often; narrow priorities give ties.
        ins_pct   = 50;
        prio_mode = 1;
        for (int n = 0; n < RANDOM_OPS; n++) begin
            if (n % 40 == 0) begin
                case ($urandom_range(2))
                    0: ins_pct = 85;
                    1: ins_pct = 15;
                    default: ins_pct = 50;
                endcase
                prio_mode = $urandom_range(2);
            end
            if (n == 600) calm = 1'b1;
            if (n == 900) calm = 1'b0;
            if (n == RANDOM_OPS / 2) drain_results();

            c   = ($urandom_range(99) < ins_pct) ? bsq_pkg::CMD_INSERT : bsq_pkg::CMD_REMOVE;
            tag = 16'($urandom_range(16'hFFFF));
            case (prio_mode)
                0: pr = 8'($urandom_range(3));
                1: pr = 8'($urandom_range(8'hFF));
                default: pr = $urandom_range(1) ? 8'hFF : 8'h00;
            endcase

            send_beat(c, tag, pr);
            due_results.push_back(apply_queue_op(c, tag, pr));
        end

        i_s_tvalid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        // wait on so a stray extra beat would still be caught
        repeat (10) @(posedge i_clk);

        if (errors == 0) begin
            $display("** bounded_sorted_priority_queue_core: PASSED **");
        end else begin
            $display("** bounded_sorted_priority_queue_core: FAILED **");
        end
        $finish;
    end

endmodule

// ----- bounded_sorted_priority_queue_core.f -----
+incdir+design
design/bsq_pkg.sv
design/bsq_ctrl.sv
design/bsq_dpath.sv
design/bounded_sorted_priority_queue_core.sv
verif/tb.sv
